// ===== hdl/urm_pkg.sv =====
// shared types and constants for the uart 16450 register model
package urm_pkg;

  // item commands
  typedef enum logic [2:0] {
    CMD_READ   = 3'd0,
    CMD_WRITE  = 3'd1,
    CMD_TXDONE = 3'd2,
    CMD_RXBYTE = 3'd3,
    CMD_LOOPDL = 3'd4,
    CMD_MODEM  = 3'd5
  } cmd_e;

  // transmit handshake codes
  typedef enum logic [1:0] {
    TXEV_NONE  = 2'd0,
    TXEV_START = 2'd1,
    TXEV_DONE  = 2'd2
  } tx_event_e;

  // register offsets
  localparam logic [2:0] REG_RBR = 3'd0;
  localparam logic [2:0] REG_IER = 3'd1;
  localparam logic [2:0] REG_IIR = 3'd2;
  localparam logic [2:0] REG_LCR = 3'd3;
  localparam logic [2:0] REG_MCR = 3'd4;
  localparam logic [2:0] REG_LSR = 3'd5;
  localparam logic [2:0] REG_MSR = 3'd6;
  localparam logic [2:0] REG_SCR = 3'd7;

  // interrupt id codes
  localparam logic [7:0] IIR_LS   = 8'h06;
  localparam logic [7:0] IIR_RX   = 8'h04;
  localparam logic [7:0] IIR_TX   = 8'h02;
  localparam logic [7:0] IIR_MS   = 8'h00;
  localparam logic [7:0] IIR_NONE = 8'h01;

  // pending source bits
  localparam int SRC_LS = 0;
  localparam int SRC_RX = 1;
  localparam int SRC_TX = 2;
  localparam int SRC_MS = 3;

  // line flag bits
  localparam int LF_DR   = 0;
  localparam int LF_THRE = 1;
  localparam int LF_TEMT = 2;

  // modem control bits
  localparam int MC_DTR  = 0;
  localparam int MC_RTS  = 1;
  localparam int MC_OUT1 = 2;
  localparam int MC_OUT2 = 3;
  localparam int MC_LOOP = 4;

  localparam int LCR_DLAB = 7;

  typedef struct packed {
    logic [2:0] cmd;
    logic [2:0] reg_addr;
    logic [7:0] write_data;
    logic [7:0] rx_data;
    logic       cts_in;
    logic       dsr_in;
    logic       ri_in;
    logic       dcd_in;
  } in_item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       irq_line;
    logic [1:0] tx_event;
    logic [7:0] tx_byte;
    logic       loop_request;
    logic       rx_request;
    logic       dtr_out;
    logic       rts_out;
    logic       ctrl_changed;
  } out_item_t;

endpackage

// ===== hdl/urm_if.sv =====
// valid/ready channel interfaces for items and results
interface urm_in_if import urm_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface urm_out_if import urm_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== hdl/urm_core.sv =====
// uart register state and single pass update logic
module urm_core import urm_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      fire_i,
  input  in_item_t  item_i,
  output out_item_t result_o
);

  logic [7:0]  lcr_q, lcr_d;
  logic [3:0]  ier_q, ier_d;
  logic [15:0] div_q, div_d;
  logic [7:0]  scr_q, scr_d;
  logic [7:0]  rbr_q, rbr_d;
  logic [7:0]  thr_q, thr_d;
  logic [7:0]  lbr_q, lbr_d;
  logic [2:0]  lsr_q, lsr_d;
  logic [3:0]  pend_q, pend_d;
  logic        irq_q, irq_d;
  logic [4:0]  mcr_q, mcr_d;
  logic [3:0]  lmcr_q, lmcr_d;
  logic [3:0]  delta_q, delta_d;
  logic [3:0]  lvl_q, lvl_d;

  always_comb begin
    logic       dl;
    logic [3:0] nb;
    logic [3:0] diff;
    logic [3:0] add;
    logic [3:0] lv;
    logic [7:0] wd;

    lcr_d   = lcr_q;
    ier_d   = ier_q;
    div_d   = div_q;
    scr_d   = scr_q;
    rbr_d   = rbr_q;
    thr_d   = thr_q;
    lbr_d   = lbr_q;
    lsr_d   = lsr_q;
    pend_d  = pend_q;
    irq_d   = irq_q;
    mcr_d   = mcr_q;
    lmcr_d  = lmcr_q;
    delta_d = delta_q;
    lvl_d   = lvl_q;
    result_o = '0;

    dl   = lcr_q[LCR_DLAB];
    wd   = item_i.write_data;
    nb   = wd[3:0];
    diff = (lmcr_q ^ nb);
    add  = '0;
    lv   = '0;

    case (item_i.cmd)
      CMD_READ: begin
        case (item_i.reg_addr)
          REG_RBR: begin
            if (dl) begin
              result_o.read_data = div_q[7:0];
            end else begin
              pend_d[SRC_RX] = 1'b0;
              if (pend_d == '0) irq_d = 1'b0;
              if (lsr_q[LF_DR]) begin
                lsr_d[LF_DR] = 1'b0;
                if (!mcr_q[MC_LOOP]) result_o.rx_request = 1'b1;
              end
              result_o.read_data = rbr_q;
            end
          end
          REG_IER: result_o.read_data = dl ? div_q[15:8] : {4'b0, ier_q};
          REG_IIR: begin
            if (pend_q[SRC_LS]) begin
              result_o.read_data = IIR_LS;
            end else if (pend_q[SRC_RX]) begin
              result_o.read_data = IIR_RX;
            end else if (pend_q[SRC_TX]) begin
              // reading the tx-empty id acknowledges it
              pend_d[SRC_TX] = 1'b0;
              if (pend_d == '0) irq_d = 1'b0;
              result_o.read_data = IIR_TX;
            end else if (pend_q[SRC_MS]) begin
              result_o.read_data = IIR_MS;
            end else begin
              result_o.read_data = IIR_NONE;
            end
          end
          REG_LCR: result_o.read_data = lcr_q;
          REG_MCR: begin
            result_o.read_data = mcr_q[MC_LOOP] ? {4'b0001, lmcr_q} : {3'b000, mcr_q};
          end
          REG_LSR: begin
            result_o.read_data = {1'b0, lsr_q[LF_TEMT], lsr_q[LF_THRE], 4'b0, lsr_q[LF_DR]};
            pend_d[SRC_LS] = 1'b0;
            if (pend_d == '0) irq_d = 1'b0;
          end
          REG_MSR: begin
            // in loopback dtr feeds dsr, rts feeds cts, out1 ri, out2 dcd
            lv = mcr_q[MC_LOOP] ? {lmcr_q[3], lmcr_q[2], lmcr_q[0], lmcr_q[1]} : lvl_q;
            result_o.read_data = {lv, delta_q};
            delta_d = '0;
            pend_d[SRC_MS] = 1'b0;
            if (pend_d == '0) irq_d = 1'b0;
          end
          default: result_o.read_data = scr_q;
        endcase
      end
      CMD_WRITE: begin
        case (item_i.reg_addr)
          REG_RBR: begin
            if (dl) begin
              div_d[7:0] = wd;
            end else begin
              thr_d = wd;
              pend_d[SRC_TX] = 1'b0;
              if (pend_d == '0) irq_d = 1'b0;
              lsr_d[LF_THRE] = 1'b0;
              lsr_d[LF_TEMT] = 1'b0;
              result_o.tx_event = TXEV_START;
              result_o.tx_byte  = wd;
              if (mcr_q[MC_LOOP]) begin
                lbr_d = wd;
                result_o.loop_request = 1'b1;
              end
            end
          end
          REG_IER: begin
            if (dl) begin
              div_d[15:8] = wd;
            end else begin
              ier_d = wd[3:0];
              if (wd[1] && lsr_q[LF_THRE]) begin
                pend_d[SRC_TX] = 1'b1;
                irq_d = 1'b1;
              end
            end
          end
          REG_LCR: lcr_d = wd;
          REG_MCR: begin
            if (wd[MC_LOOP]) begin
              // loopback bit changes raise deltas, teri only on falling out1
              add[1] = diff[0] & ~delta_q[1];
              add[0] = diff[1] & ~delta_q[0];
              add[2] = diff[2] & ~nb[2] & ~delta_q[2];
              add[3] = diff[3] & ~delta_q[3];
              delta_d = delta_q | add;
              if ((add != '0) && ier_q[SRC_MS]) begin
                pend_d[SRC_MS] = 1'b1;
                irq_d = 1'b1;
              end
              lmcr_d = nb;
              mcr_d  = 5'b10000;
            end else begin
              mcr_d = {1'b0, nb};
              result_o.ctrl_changed = 1'b1;
            end
          end
          REG_MSR: delta_d = wd[3:0];
          REG_SCR: scr_d = wd;
          default: ;
        endcase
      end
      CMD_TXDONE: begin
        lsr_d[LF_THRE] = 1'b1;
        lsr_d[LF_TEMT] = 1'b1;
        if (ier_q[1]) begin
          pend_d[SRC_TX] = 1'b1;
          irq_d = 1'b1;
        end
        result_o.tx_event = TXEV_DONE;
        result_o.tx_byte  = thr_q;
      end
      CMD_RXBYTE, CMD_LOOPDL: begin
        rbr_d = (item_i.cmd == CMD_RXBYTE) ? item_i.rx_data : lbr_q;
        lsr_d[LF_DR] = 1'b1;
        if (ier_q[0]) begin
          pend_d[SRC_RX] = 1'b1;
          irq_d = 1'b1;
        end
      end
      CMD_MODEM: begin
        lv = {item_i.dcd_in, item_i.ri_in, item_i.dsr_in, item_i.cts_in};
        if (lv[1] != lvl_q[1]) begin
          delta_d[1] = 1'b1;
          if (ier_q[SRC_MS]) begin
            pend_d[SRC_MS] = 1'b1;
            irq_d = 1'b1;
          end
        end
        lvl_d = lv;
      end
      default: ;
    endcase

    result_o.irq_line = irq_d & mcr_d[MC_OUT2];
    result_o.dtr_out  = mcr_d[MC_DTR];
    result_o.rts_out  = mcr_d[MC_RTS];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lcr_q   <= '0;
      ier_q   <= '0;
      div_q   <= '0;
      scr_q   <= '0;
      rbr_q   <= '0;
      thr_q   <= '0;
      lbr_q   <= '0;
      lsr_q   <= 3'b110;
      pend_q  <= '0;
      irq_q   <= 1'b0;
      mcr_q   <= '0;
      lmcr_q  <= '0;
      delta_q <= '0;
      lvl_q   <= '0;
    end else if (fire_i) begin
      lcr_q   <= lcr_d;
      ier_q   <= ier_d;
      div_q   <= div_d;
      scr_q   <= scr_d;
      rbr_q   <= rbr_d;
      thr_q   <= thr_d;
      lbr_q   <= lbr_d;
      lsr_q   <= lsr_d;
      pend_q  <= pend_d;
      irq_q   <= irq_d;
      mcr_q   <= mcr_d;
      lmcr_q  <= lmcr_d;
      delta_q <= delta_d;
      lvl_q   <= lvl_d;
    end
  end

endmodule

// ===== hdl/urm_stage.sv =====
// input item register and result register around the update logic
module urm_stage import urm_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  urm_in_if.sink    in_i,
  urm_out_if.source out_o,
  output logic      fire_o,
  output in_item_t  item_o,
  input  out_item_t result_i
);

  logic      in_valid_q;
  in_item_t  in_item_q;
  logic      out_valid_q;
  out_item_t out_item_q;
  logic      advance;

  // result slot is free when empty or being taken this cycle
  assign advance   = !out_valid_q || out_o.ready;
  assign in_i.ready = !in_valid_q || advance;
  assign fire_o    = in_valid_q && advance;
  assign item_o    = in_item_q;

  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_i.ready) in_valid_q <= in_i.valid;
      if (advance) out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) in_item_q <= in_i.payload;
    if (fire_o) out_item_q <= result_i;
  end

endmodule

// ===== hdl/uart_16450_register_model.sv =====
// uart 16450 register file top level
// an item transfer passes through the input register, then the result register, before
// its result can transfer; each item is resolved in one update pass
// throughput: one item per cycle; stalls come only from the result channel ready
// reset: asynchronous active low; thre and temt set, every other register cleared,
// both pipeline slots empty
module uart_16450_register_model import urm_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  urm_in_if.sink    in_i,
  urm_out_if.source out_o
);

  // handshake between the pipeline registers and the register file
  logic      fire;
  in_item_t  item;
  out_item_t result;

  // input register and result register, ready chains back from the result side
  urm_stage u_stage (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .out_o    (out_o),
    .fire_o   (fire),
    .item_o   (item),
    .result_i (result)
  );

  // register file state, interrupt pending bits and modem logic; state commits on fire
  urm_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (fire),
    .item_i   (item),
    .result_o (result)
  );

endmodule

// ===== bench/tb_uart_16450_register_model.sv =====
`timescale 1ns / 100ps
// self-checking testbench for the uart 16450 register file
module tb_uart_16450_register_model;
  import urm_pkg::*;

  // command codes the block must ignore
  localparam logic [2:0] CMD_RSVD_A = 3'd6;
  localparam logic [2:0] CMD_RSVD_B = 3'd7;

  logic clk;
  logic rst_n;

  urm_in_if  in_if ();
  urm_out_if out_if ();

  uart_16450_register_model u_top (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // one row of the directed table; typed rows carry a hand-written read value
  typedef struct {
    in_item_t  item;
    bit        typed;
    out_item_t want;
  } dir_row_t;

  dir_row_t  dir_rows[$];
  out_item_t reg_result_q[$];   // results still owed by the block, oldest first
  int        mismatch_count;
  int        burst_left;

  // shadow copy of the register file
  logic [7:0]  lcr_q;
  logic [3:0]  ier_q;
  logic [15:0] div_q;
  logic [7:0]  scr_q;
  logic [7:0]  rbr_q;
  logic [7:0]  thr_q;
  logic [7:0]  loop_byte_q;
  logic [2:0]  lsr_flags_q;
  logic [3:0]  pend_q;
  logic        irq_q;
  logic [4:0]  mcr_q;
  logic [3:0]  loop_mcr_q;
  logic [3:0]  msr_delta_q;
  logic [3:0]  msr_level_q;

  // clock, 8 ns period
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // reset held low at start, released on a falling edge, never asserted again
  initial begin
    rst_n = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
  end

  // hard limit on the whole run
  initial begin
    #2000000;
    $display("tb_uart_16450_register_model failed");
    $finish;
  end

  // interrupt source bookkeeping, shared by several paths below
  function automatic void raise_src(input int src);
    pend_q[src] = 1'b1;
    irq_q = 1'b1;
  endfunction

  function automatic void drop_src(input int src);
    pend_q[src] = 1'b0;
    if (pend_q == 4'h0) irq_q = 1'b0;
  endfunction

  // a byte lands in the receive buffer, from the line or from loopback
  function automatic void land_rx_byte(input logic [7:0] b);
    rbr_q = b;
    lsr_flags_q[LF_DR] = 1'b1;
    if (ier_q[0]) raise_src(SRC_RX);
  endfunction

  // advance the shadow register file by one item and return its result
  function automatic out_item_t uart_regs_step(input in_item_t it);
    out_item_t  r;
    logic       dl;
    logic [3:0] lv;
    logic [3:0] diff;
    logic [3:0] add;
    logic [3:0] nb;
    r = '0;
    dl = lcr_q[LCR_DLAB];
    case (it.cmd)
      CMD_READ: begin
        case (it.reg_addr)
          REG_RBR: begin
            if (dl) begin
              r.read_data = div_q[7:0];
            end else begin
              drop_src(SRC_RX);
              // a read that empties the buffer asks for the next byte, except in loopback
              if (lsr_flags_q[LF_DR]) begin
                lsr_flags_q[LF_DR] = 1'b0;
                if (!mcr_q[MC_LOOP]) r.rx_request = 1'b1;
              end
              r.read_data = rbr_q;
            end
          end
          REG_IER: r.read_data = dl ? div_q[15:8] : {4'h0, ier_q};
          REG_IIR: begin
            // highest priority source wins; only the tx empty id is cleared by the read
            if (pend_q[SRC_LS]) r.read_data = IIR_LS;
            else if (pend_q[SRC_RX]) r.read_data = IIR_RX;
            else if (pend_q[SRC_TX]) begin
              drop_src(SRC_TX);
              r.read_data = IIR_TX;
            end else if (pend_q[SRC_MS]) r.read_data = IIR_MS;
            else r.read_data = IIR_NONE;
          end
          REG_LCR: r.read_data = lcr_q;
          REG_MCR: begin
            if (mcr_q[MC_LOOP]) r.read_data = {4'h1, loop_mcr_q};
            else r.read_data = {3'h0, mcr_q};
          end
          REG_LSR: begin
            r.read_data[0] = lsr_flags_q[LF_DR];
            r.read_data[5] = lsr_flags_q[LF_THRE];
            r.read_data[6] = lsr_flags_q[LF_TEMT];
            drop_src(SRC_LS);
          end
          REG_MSR: begin
            // in loopback rts drives cts, dtr drives dsr, out1 drives ri, out2 drives dcd
            if (mcr_q[MC_LOOP]) lv = {loop_mcr_q[3], loop_mcr_q[2], loop_mcr_q[0], loop_mcr_q[1]};
            else lv = msr_level_q;
            r.read_data = {lv, msr_delta_q};
            msr_delta_q = 4'h0;
            drop_src(SRC_MS);
          end
          default: r.read_data = scr_q;
        endcase
      end
      CMD_WRITE: begin
        case (it.reg_addr)
          REG_RBR: begin
            if (dl) begin
              div_q[7:0] = it.write_data;
            end else begin
              thr_q = it.write_data;
              drop_src(SRC_TX);
              lsr_flags_q[LF_THRE] = 1'b0;
              lsr_flags_q[LF_TEMT] = 1'b0;
              r.tx_event = TXEV_START;
              r.tx_byte = it.write_data;
              if (mcr_q[MC_LOOP]) begin
                loop_byte_q = it.write_data;
                r.loop_request = 1'b1;
              end
            end
          end
          REG_IER: begin
            if (dl) begin
              div_q[15:8] = it.write_data;
            end else begin
              ier_q = it.write_data[3:0];
              // enabling thr empty while the holding register is empty fires at once
              if (it.write_data[1] && lsr_flags_q[LF_THRE]) raise_src(SRC_TX);
            end
          end
          REG_LCR: lcr_q = it.write_data;
          REG_MCR: begin
            nb = it.write_data[3:0];
            if (it.write_data[4]) begin
              // loopback: changes on the looped bits show up as msr deltas
              diff = loop_mcr_q ^ nb;
              add = 4'h0;
              if (diff[0] && !msr_delta_q[1]) add[1] = 1'b1;
              if (diff[1] && !msr_delta_q[0]) add[0] = 1'b1;
              if (diff[2] && !nb[2] && !msr_delta_q[2]) add[2] = 1'b1;
              if (diff[3] && !msr_delta_q[3]) add[3] = 1'b1;
              msr_delta_q = msr_delta_q | add;
              if (add != 4'h0 && ier_q[3]) raise_src(SRC_MS);
              loop_mcr_q = nb;
              mcr_q = '0;
              mcr_q[MC_LOOP] = 1'b1;
            end else begin
              mcr_q = {1'b0, nb};
              r.ctrl_changed = 1'b1;
            end
          end
          REG_MSR: msr_delta_q = it.write_data[3:0];
          REG_SCR: scr_q = it.write_data;
          default: ;
        endcase
      end
      CMD_TXDONE: begin
        lsr_flags_q[LF_THRE] = 1'b1;
        lsr_flags_q[LF_TEMT] = 1'b1;
        if (ier_q[1]) raise_src(SRC_TX);
        r.tx_event = TXEV_DONE;
        r.tx_byte = thr_q;
      end
      CMD_RXBYTE: land_rx_byte(it.rx_data);
      CMD_LOOPDL: land_rx_byte(loop_byte_q);
      CMD_MODEM: begin
        lv = {it.dcd_in, it.ri_in, it.dsr_in, it.cts_in};
        // only a dsr change is tracked as a delta on the line side
        if (lv[1] != msr_level_q[1]) begin
          msr_delta_q[1] = 1'b1;
          if (ier_q[3]) raise_src(SRC_MS);
        end
        msr_level_q = lv;
      end
      default: ;
    endcase
    r.irq_line = irq_q & mcr_q[MC_OUT2];
    r.dtr_out = mcr_q[MC_DTR];
    r.rts_out = mcr_q[MC_RTS];
    return r;
  endfunction

  function automatic void add_row(input logic [2:0] cmd, input logic [2:0] addr,
                                  input logic [7:0] wd, input logic [7:0] rd,
                                  input logic [3:0] lines, input bit typed,
                                  input logic [7:0] want_rd);
    dir_row_t row;
    row.item = '0;
    row.item.cmd = cmd;
    row.item.reg_addr = addr;
    row.item.write_data = wd;
    row.item.rx_data = rd;
    row.item.cts_in = lines[0];
    row.item.dsr_in = lines[1];
    row.item.ri_in = lines[2];
    row.item.dcd_in = lines[3];
    row.typed = typed;
    row.want = '0;
    row.want.read_data = want_rd;
    dir_rows.push_back(row);
  endfunction

  // sender pacing: bursts of random length, random gaps between them
  task automatic pace();
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) == 0) burst_left = $urandom_range(30, 80);
      else burst_left = $urandom_range(1, 12);
      repeat ($urandom_range(0, 5)) begin
        @(negedge clk);
        in_if.valid <= 1'b0;
      end
    end
    burst_left--;
  endtask

  // drive one item, wait for its transfer, then log what the block owes for it
  task automatic send_item(input in_item_t it, input bit typed, input out_item_t want);
    out_item_t pred;
    pace();
    @(negedge clk);
    in_if.valid <= 1'b1;
    in_if.payload <= it;
    do @(posedge clk); while (in_if.ready !== 1'b1);
    pred = uart_regs_step(it);
    reg_result_q.push_back(typed ? want : pred);
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatch_count++;
    end
  endtask

  // result receiver: stretches of always ready, coin flip, mostly stalled, or a rotating pattern
  initial begin : result_sink
    int         mode;
    int         left;
    logic [7:0] pat;
    out_if.ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      mode = $urandom_range(0, 3);
      left = $urandom_range(8, 64);
      pat = 8'($urandom);
      repeat (left) begin
        @(negedge clk);
        case (mode)
          0: out_if.ready <= 1'b1;
          1: out_if.ready <= 1'($urandom_range(0, 1));
          2: out_if.ready <= ($urandom_range(0, 7) == 0);
          default: begin
            out_if.ready <= pat[0];
            pat = {pat[0], pat[7:1]};
          end
        endcase
      end
    end
  end

  // result checker, sampled on the rising edge
  always @(posedge clk) begin : result_check
    out_item_t got;
    out_item_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      got = out_if.payload;
      if (reg_result_q.size() == 0) begin
        $error("result transfer with nothing outstanding: %h", got);
        mismatch_count++;
      end else begin
        want = reg_result_q.pop_front();
        check_field("read_data", want.read_data, got.read_data);
        check_field("irq_line", 8'(want.irq_line), 8'(got.irq_line));
        check_field("tx_event", 8'(want.tx_event), 8'(got.tx_event));
        check_field("tx_byte", want.tx_byte, got.tx_byte);
        check_field("loop_request", 8'(want.loop_request), 8'(got.loop_request));
        check_field("rx_request", 8'(want.rx_request), 8'(got.rx_request));
        check_field("dtr_out", 8'(want.dtr_out), 8'(got.dtr_out));
        check_field("rts_out", 8'(want.rts_out), 8'(got.rts_out));
        check_field("ctrl_changed", 8'(want.ctrl_changed), 8'(got.ctrl_changed));
      end
    end
  end

  // stimulus: directed table, then random traffic
  initial begin : item_feed
    in_item_t it;
    int       pick;
    in_if.valid <= 1'b0;
    in_if.payload <= '0;
    mismatch_count = 0;
    burst_left = 0;

    // shadow state after reset: thre and temt set, the rest clear
    lcr_q = '0; ier_q = '0; div_q = '0; scr_q = '0;
    rbr_q = '0; thr_q = '0; loop_byte_q = '0;
    lsr_flags_q = '0;
    lsr_flags_q[LF_THRE] = 1'b1;
    lsr_flags_q[LF_TEMT] = 1'b1;
    pend_q = '0; irq_q = 1'b0;
    mcr_q = '0; loop_mcr_q = '0; msr_delta_q = '0; msr_level_q = '0;

    // reset values, scratch and divisor extremes
    add_row(CMD_READ,   REG_LSR, 8'h00, 8'h00, 4'h0, 1'b1, 8'h60);
    add_row(CMD_READ,   REG_IIR, 8'h00, 8'h00, 4'h0, 1'b1, IIR_NONE);
    add_row(CMD_WRITE,  REG_SCR, 8'hFF, 8'h00, 4'h0, 1'b1, 8'h00);
    add_row(CMD_READ,   REG_SCR, 8'h00, 8'h00, 4'h0, 1'b1, 8'hFF);
    add_row(CMD_WRITE,  REG_LCR, 8'h80, 8'h00, 4'h0, 1'b1, 8'h00);
    add_row(CMD_WRITE,  REG_RBR, 8'hFF, 8'h00, 4'h0, 1'b1, 8'h00);
    add_row(CMD_WRITE,  REG_IER, 8'h00, 8'h00, 4'h0, 1'b1, 8'h00);
    add_row(CMD_READ,   REG_RBR, 8'h00, 8'h00, 4'h0, 1'b1, 8'hFF);
    add_row(CMD_WRITE,  REG_LCR, 8'h03, 8'h00, 4'h0, 1'b1, 8'h00);
    // enabling thr empty with thre set, then out2 gates the irq line
    add_row(CMD_WRITE,  REG_IER, 8'h0F, 8'h00, 4'h0, 1'b0, 8'h00);
    add_row(CMD_WRITE,  REG_MCR, 8'h0B, 8'h00, 4'h0, 1'b0, 8'h00);
    add_row(CMD_READ,   REG_IIR, 8'h00, 8'h00, 4'h0, 1'b0, 8'h00);
    // transmit start and done, receive and buffer read
    add_row(CMD_WRITE,  REG_RBR, 8'h00, 8'h00, 4'h0, 1'b0, 8'h00);
    add_row(CMD_TXDONE, REG_RBR, 8'h00, 8'h00, 4'h0, 1'b0, 8'h00);
    add_row(CMD_RXBYTE, REG_RBR, 8'h00, 8'hFF, 4'h0, 1'b0, 8'h00);
    add_row(CMD_RXBYTE, REG_RBR, 8'h00, 8'h5A, 4'h0, 1'b0, 8'h00);
    add_row(CMD_READ,   REG_IIR, 8'h00, 8'h00, 4'h0, 1'b0, 8'h00);
    add_row(CMD_READ,   REG_RBR, 8'h00, 8'h00, 4'h0, 1'b0, 8'h00);
    // modem lines and status read
    add_row(CMD_MODEM,  REG_RBR, 8'h00, 8'h00, 4'hF, 1'b0, 8'h00);
    add_row(CMD_READ,   REG_MSR, 8'h00, 8'h00, 4'h0, 1'b0, 8'h00);
    // loopback: deltas from mcr, looped byte, no rx request on the buffer read
    add_row(CMD_WRITE,  REG_MCR, 8'h1F, 8'h00, 4'h0, 1'b0, 8'h00);
    add_row(CMD_WRITE,  REG_RBR, 8'hA5, 8'h00, 4'h0, 1'b0, 8'h00);
    add_row(CMD_LOOPDL, REG_RBR, 8'h00, 8'h00, 4'h0, 1'b0, 8'h00);
    add_row(CMD_READ,   REG_RBR, 8'h00, 8'h00, 4'h0, 1'b0, 8'h00);
    add_row(CMD_READ,   REG_MCR, 8'h00, 8'h00, 4'h0, 1'b0, 8'h00);
    add_row(CMD_READ,   REG_MSR, 8'h00, 8'h00, 4'h0, 1'b0, 8'h00);
    // msr delta write, ignored offsets, unused commands
    add_row(CMD_WRITE,  REG_MSR, 8'h0F, 8'h00, 4'h0, 1'b0, 8'h00);
    add_row(CMD_WRITE,  REG_IIR, 8'hFF, 8'h00, 4'h0, 1'b0, 8'h00);
    add_row(CMD_WRITE,  REG_LSR, 8'hFF, 8'h00, 4'h0, 1'b0, 8'h00);
    add_row(CMD_RSVD_A, REG_RBR, 8'h00, 8'h00, 4'h0, 1'b0, 8'h00);
    add_row(CMD_RSVD_B, REG_RBR, 8'h00, 8'h00, 4'h0, 1'b0, 8'h00);

    @(posedge rst_n);
    foreach (dir_rows[i]) send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);

    // random traffic, all payload bits random, command mix weighted toward bus access
    repeat (1000) begin
      it = in_item_t'({$urandom, $urandom});
      pick = $urandom_range(0, 99);
      if (pick < 36) it.cmd = CMD_READ;
      else if (pick < 66) begin
        it.cmd = CMD_WRITE;
        // keep dlab and loopback on for a minority of the time
        if (it.reg_addr == REG_LCR) it.write_data[LCR_DLAB] = ($urandom_range(0, 3) == 0);
        if (it.reg_addr == REG_MCR) it.write_data[MC_LOOP] = ($urandom_range(0, 2) == 0);
      end
      else if (pick < 74) it.cmd = CMD_TXDONE;
      else if (pick < 84) it.cmd = CMD_RXBYTE;
      else if (pick < 90) it.cmd = CMD_LOOPDL;
      else if (pick < 98) it.cmd = CMD_MODEM;
      else if (pick == 98) it.cmd = CMD_RSVD_A;
      else it.cmd = CMD_RSVD_B;
      send_item(it, 1'b0, '0);
    end

    @(negedge clk);
    in_if.valid <= 1'b0;

    // drain, then allow the pipeline latency for any stray transfer
    while (reg_result_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("tb_uart_16450_register_model passed");
    end else begin
      $display("tb_uart_16450_register_model failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/urm_pkg.sv
hdl/urm_if.sv
hdl/urm_core.sv
hdl/urm_stage.sv
hdl/uart_16450_register_model.sv
bench/tb_uart_16450_register_model.sv
